[rtl/core/lco_pkg.sv]
// ----------------------------------------------------------------------------
// lco_pkg
// Shared types, constants and the gray reduction for the label contour
// overlay: line-buffer entry layout, position flags and result word.
// ----------------------------------------------------------------------------
package lco_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WDT_W     = 11;
    localparam int HGT_W     = 13;
    localparam int ROW_W     = 13;
    localparam int RGB_W     = 24;
    localparam int GRAY_W    = 8;
    localparam int IDX_W     = 2;

    localparam logic [WDT_W-1:0] WIDTH_RST  = WDT_W'(640);
    localparam logic [HGT_W-1:0] HEIGHT_RST = HGT_W'(480);
    localparam logic [RGB_W-1:0] COLOR_RST  = RGB_W'(24'hFF0000);

    typedef enum logic [IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_COLOR  = 2'd2
    } t_cfg_idx;

    // One line-buffer column: pixel and gray of the last row, gray of the row above it
    typedef struct packed {
        logic [RGB_W-1:0]  img;
        logic [GRAY_W-1:0] gray;
        logic [GRAY_W-1:0] up;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] rd_addr;
        logic             data;
        logic             has_out;
        logic             up_ok;
        logic             left_ok;
        logic             right_ok;
        logic             last;
    } t_pos;

    typedef struct packed {
        logic [RGB_W-1:0] rgb;
        logic             contour;
        logic             last;
    } t_result;

    function automatic logic [GRAY_W-1:0] gray_of(input logic [RGB_W-1:0] rgb);
        logic [12:0] sum;
        sum = 13'(rgb[23:16]) * 13'd11 + {1'b0, rgb[15:8], 4'b0000}
            + 13'(rgb[7:0]) * 13'd5;
        return sum[12:5];
    endfunction

endpackage

[rtl/core/lco_ram.sv]
// ----------------------------------------------------------------------------
// lco_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
module lco_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/lco_seq.sv]
// ----------------------------------------------------------------------------
// lco_seq
// Raster position sequencer: input column and row counters, the flags that
// qualify neighbors, and the line-buffer prefetch address two columns ahead.
// ----------------------------------------------------------------------------
module lco_seq
    import lco_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_restart,
    input  logic [WDT_W-1:0] i_width,
    input  logic [HGT_W-1:0] i_height,
    output t_pos             o_pos
);

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [WDT_W-1:0] col_inc;
    logic [WDT_W-1:0] ahead0, ahead1, ahead2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_comb begin
        col_inc = WDT_W'(r_col) + WDT_W'(1);
        n_col   = r_col;
        n_row   = r_row;
        if (i_restart) begin
            n_col = '0;
            n_row = '0;
        end else if (i_step) begin
            if (col_inc >= i_width) begin
                n_col = '0;
                // the flush row is the last one; wrap to the next frame after it
                if (r_row >= ROW_W'(i_height)) begin
                    n_row = '0;
                end else begin
                    n_row = r_row + ROW_W'(1);
                end
            end else begin
                n_col = col_inc[COL_W-1:0];
            end
        end
    end

    // prefetch column (col + 2) mod width
    always_comb begin
        ahead0 = WDT_W'(r_col) + WDT_W'(2);
        ahead1 = (ahead0 >= i_width) ? ahead0 - i_width : ahead0;
        ahead2 = (ahead1 >= i_width) ? ahead1 - i_width : ahead1;
    end

    always_comb begin
        o_pos.col      = r_col;
        o_pos.rd_addr  = ahead2[COL_W-1:0];
        o_pos.data     = r_row < ROW_W'(i_height);
        o_pos.has_out  = r_row != '0;
        o_pos.up_ok    = r_row >= ROW_W'(2);
        o_pos.left_ok  = r_col != '0;
        o_pos.right_ok = col_inc < i_width;
        o_pos.last     = (r_row == ROW_W'(i_height)) && (col_inc == i_width);
    end

endmodule

[rtl/core/lco_edge.sv]
// ----------------------------------------------------------------------------
// lco_edge
// Neighbor window over the line buffer: holds the center and left columns,
// forwards a same-cycle write to the prefetch slot, judges the boundary and
// builds the write-back entry.
// ----------------------------------------------------------------------------
module lco_edge
    import lco_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  t_pos             i_pos,
    input  t_entry           i_rd_data,
    input  logic [RGB_W-1:0] i_label,
    input  logic [RGB_W-1:0] i_image,
    input  logic [RGB_W-1:0] i_color,
    output logic             o_wr_en,
    output t_entry           o_wr_data,
    output t_result          o_result
);

    t_entry            r_cur;
    t_entry            r_fwd_data;
    logic              r_fwd;
    logic [GRAY_W-1:0] r_left;
    t_entry            right;
    logic [GRAY_W-1:0] g;
    logic              edge_hit;

    assign g     = gray_of(i_label);
    assign right = r_fwd ? r_fwd_data : i_rd_data;

    assign o_wr_en   = i_step && i_pos.data;
    assign o_wr_data = '{img: i_image, gray: g, up: r_cur.gray};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_step) begin
            // prefetch hits the column written this cycle on narrow frames
            r_fwd <= o_wr_en && (i_pos.rd_addr == i_pos.col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_fwd_data <= o_wr_data;
            // one column wide: the next center is the word written right now
            if (o_wr_en && !i_pos.left_ok && !i_pos.right_ok) begin
                r_cur <= o_wr_data;
            end else begin
                r_cur <= right;
            end
            r_left     <= r_cur.gray;
        end
    end

    always_comb begin
        edge_hit = 1'b0;
        if (i_pos.up_ok && r_cur.up != r_cur.gray) edge_hit = 1'b1;
        if (i_pos.data && g != r_cur.gray) edge_hit = 1'b1;
        if (i_pos.left_ok && r_left != r_cur.gray) edge_hit = 1'b1;
        if (i_pos.right_ok && right.gray != r_cur.gray) edge_hit = 1'b1;
        o_result.rgb     = edge_hit ? i_color : r_cur.img;
        o_result.contour = edge_hit;
        o_result.last    = i_pos.last;
    end

endmodule

[rtl/core/label_contour_overlay.sv]
// ----------------------------------------------------------------------------
// label_contour_overlay
// Label boundary overlay on a raster pixel stream.
// ----------------------------------------------------------------------------
// Input words carry a label pixel, an image pixel and a drain flag; one word
// is taken per cycle when the output side keeps up. The result for a pixel
// leaves on the output channel in the cycle after the word one row below it
// (frame_width words later) is accepted, so the first row gives no output.
// After the last row, frame_width drain words flush it; words of that flush
// row count as drain whatever their flag. A drain word inside the pixel rows
// is taken and dropped. tlast marks the final pixel of the frame.
// Throughput is one word per cycle while the receiver keeps up, set by the
// single line-buffer memory: each word reads the column two ahead and writes
// its own column back. A single output register decouples the sides; while it
// holds an untaken word and the receiver stalls, the input is not ready.
// Reset restores the geometry and color defaults and returns to row 0;
// writing width or height also restarts the frame. Config writes are always
// ready and belong in idle time.
// ----------------------------------------------------------------------------
module label_contour_overlay
    import lco_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [2*RGB_W-1:0]     i_s_axis_tdata,   // label_rgb, image_rgb
    input  logic                   i_s_axis_tuser,   // drain
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [RGB_W-1:0]       o_m_axis_tdata,   // pixel_rgb
    output logic                   o_m_axis_tuser,   // is_contour
    output logic                   o_m_axis_tlast,   // frame_last
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [IDX_W-1:0]       i_cfg_index,
    input  logic [RGB_W-1:0]       i_cfg_data
);

    logic [WDT_W-1:0] r_frame_width;
    logic [HGT_W-1:0] r_frame_height;
    logic [RGB_W-1:0] r_color;
    logic [WDT_W-1:0] eff_width;
    logic [HGT_W-1:0] eff_height;
    logic             cfg_wr;
    logic             restart;
    logic             accept;
    logic             step;
    t_pos             pos;
    t_entry           rd_data;
    t_entry           wr_data;
    logic             wr_en;
    t_result          result;
    logic             r_out_valid;
    t_result          r_out;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RST;
            r_frame_height <= HEIGHT_RST;
            r_color        <= COLOR_RST;
        end else if (cfg_wr) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_frame_width  <= i_cfg_data[WDT_W-1:0];
                CFG_HEIGHT: r_frame_height <= i_cfg_data[HGT_W-1:0];
                CFG_COLOR:  r_color        <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (t_cfg_idx'(i_cfg_index))
            CFG_WIDTH:  restart = cfg_wr;
            CFG_HEIGHT: restart = cfg_wr;
            default:    restart = 1'b0;
        endcase
    end

    always_comb begin
        if (r_frame_width == '0) begin
            eff_width = WDT_W'(1);
        end else if (r_frame_width > WDT_W'(MAX_WIDTH)) begin
            eff_width = WDT_W'(MAX_WIDTH);
        end else begin
            eff_width = r_frame_width;
        end
        eff_height = (r_frame_height == '0) ? HGT_W'(1) : r_frame_height;
    end

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    // drop drain words inside pixel rows without advancing
    assign step            = accept && !(pos.data && i_s_axis_tuser);

    lco_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_restart (restart),
        .i_width   (eff_width),
        .i_height  (eff_height),
        .o_pos     (pos)
    );

    lco_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (pos.col),
        .i_wr_data (wr_data),
        .i_rd_en   (step),
        .i_rd_addr (pos.rd_addr),
        .o_rd_data (rd_data)
    );

    lco_edge u_edge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_pos     (pos),
        .i_rd_data (rd_data),
        .i_label   (i_s_axis_tdata[RGB_W-1:0]),
        .i_image   (i_s_axis_tdata[2*RGB_W-1:RGB_W]),
        .i_color   (r_color),
        .o_wr_en   (wr_en),
        .o_wr_data (wr_data),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && pos.has_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && pos.has_out) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.rgb;
    assign o_m_axis_tuser  = r_out.contour;
    assign o_m_axis_tlast  = r_out.last;

endmodule
